// ----- rtl/core/assert_macros.svh -----
// Assertion shorthands shared by the core modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define DAD_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("date_add_days: assertion failed");

`define DAD_ASSERT_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("date_add_days: forbidden condition seen");

`else

`define DAD_ASSERT(lbl, clk, rst_n, prop)

`define DAD_ASSERT_NEVER(lbl, clk, rst_n, cond)

`endif

`endif

// ----- rtl/core/dad_pkg.sv -----
package dad_pkg;

  localparam int unsigned ADD_DAYS_BITS_DEF = 16;

  localparam int unsigned DAY_OUT_W = 5;
  localparam int unsigned MONTH_W   = 4;
  localparam int unsigned YEAR_W    = 14;

  localparam logic [YEAR_W-1:0]    YEAR_MAX   = YEAR_W'(9999);
  localparam logic [YEAR_W-1:0]    YEAR_CYCLE = YEAR_W'(400);
  localparam logic [MONTH_W-1:0]   MONTH_JAN  = MONTH_W'(1);
  localparam logic [MONTH_W-1:0]   MONTH_DEC  = MONTH_W'(12);
  localparam logic [DAY_OUT_W-1:0] DAY_SAT    = DAY_OUT_W'(31);

  // Binary reduction of the year modulo 400: 400 << 5 .. 400 << 0
  localparam int unsigned REDUCE_STEPS = 6;
  localparam int unsigned SHIFT_W      = $clog2(REDUCE_STEPS);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_REDUCE,
    ST_WALK
  } state_t;

  typedef struct packed {
    logic               load;
    logic               reduce;
    logic [SHIFT_W-1:0] shift;
    logic               walk;
    logic               capture;
  } dp_cmd_t;

  typedef struct packed {
    logic done;
  } dp_sts_t;

  function automatic logic [DAY_OUT_W-1:0] month_days(input logic leap,
                                                      input logic [MONTH_W-1:0] month);
    logic [DAY_OUT_W-1:0] len;
    unique case (month)
      4'd2:                      len = leap ? DAY_OUT_W'(29) : DAY_OUT_W'(28);
      4'd4, 4'd6, 4'd9, 4'd11:   len = DAY_OUT_W'(30);
      default:                   len = DAY_OUT_W'(31);
    endcase
    return len;
  endfunction

endpackage

// ----- rtl/core/dad_ctrl.sv -----
`include "assert_macros.svh"

module dad_ctrl
  import dad_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_stall,
  output logic    out_valid,
  input  logic    out_stall,
  output dp_cmd_t cmd,
  input  dp_sts_t sts
);

  state_t             state_r, state_nxt;
  logic [SHIFT_W-1:0] cnt_r, cnt_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic               accept;

  assign in_stall  = (state_r != ST_IDLE);
  assign accept    = in_valid && (state_r == ST_IDLE);
  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r;
    cmd           = '0;
    cmd.shift     = cnt_r;

    // drop the result once the downstream transfer completes
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          cmd.load  = 1'b1;
          cnt_nxt   = SHIFT_W'(REDUCE_STEPS - 1);
          state_nxt = ST_REDUCE;
        end
      end
      ST_REDUCE: begin
        cmd.reduce = 1'b1;
        if (cnt_r == '0) begin
          state_nxt = ST_WALK;
        end else begin
          cnt_nxt = cnt_r - SHIFT_W'(1);
        end
      end
      ST_WALK: begin
        if (!sts.done) begin
          cmd.walk = 1'b1;
        end else if (!out_valid_r || !out_stall) begin
          // hold here while the previous result still waits
          cmd.capture   = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  `DAD_ASSERT(a_accept_starts_reduce, clk, rst_n,
    accept |=> (state_r == ST_REDUCE) && (cnt_r == SHIFT_W'(REDUCE_STEPS - 1)))
  `DAD_ASSERT(a_reduce_ends_in_walk, clk, rst_n,
    (state_r == ST_REDUCE) && (cnt_r == '0) |=> state_r == ST_WALK)
  `DAD_ASSERT_NEVER(a_no_overwrite, clk, rst_n,
    cmd.capture && out_valid_r && out_stall)

endmodule

// ----- rtl/core/dad_datapath.sv -----
`include "assert_macros.svh"

module dad_datapath
  import dad_pkg::*;
#(
  parameter int unsigned ADD_DAYS_BITS = ADD_DAYS_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  dp_cmd_t                  cmd,
  output dp_sts_t                  sts,
  input  logic [DAY_OUT_W-1:0]     in_start_day,
  input  logic [MONTH_W-1:0]       in_start_month,
  input  logic [YEAR_W-1:0]        in_start_year,
  input  logic [ADD_DAYS_BITS-1:0] in_add_days,
  output logic [DAY_OUT_W-1:0]     out_result_day,
  output logic [MONTH_W-1:0]       out_result_month,
  output logic [YEAR_W-1:0]        out_result_year,
  output logic                     out_year_overflow
);

  localparam int unsigned DAY_W = ADD_DAYS_BITS + 1;

  logic [DAY_W-1:0]     day_r;
  logic [MONTH_W-1:0]   month_r;
  logic [YEAR_W-1:0]    year_r;
  logic [YEAR_W-1:0]    rem_r;
  logic                 ovf_r;

  logic [DAY_OUT_W-1:0] res_day_r;
  logic [MONTH_W-1:0]   res_month_r;
  logic [YEAR_W-1:0]    res_year_r;
  logic                 res_ovf_r;

  logic [MONTH_W-1:0]   month_fix;
  logic [YEAR_W-1:0]    sub_val;
  logic                 leap;
  logic [DAY_W-1:0]     len;
  logic                 fits;

  always_comb begin
    if (in_start_month == '0) begin
      month_fix = MONTH_JAN;
    end else if (in_start_month > MONTH_DEC) begin
      month_fix = MONTH_DEC;
    end else begin
      month_fix = in_start_month;
    end
  end

  assign sub_val = YEAR_CYCLE << cmd.shift;

  // rem_r is year mod 400 once the reduction is done
  assign leap = (rem_r[1:0] == 2'b00) &&
                (rem_r != YEAR_W'(100)) && (rem_r != YEAR_W'(200)) &&
                (rem_r != YEAR_W'(300));
  assign len  = DAY_W'(month_days(leap, month_r));
  assign fits = (day_r <= len);

  assign sts.done = ovf_r || fits;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ovf_r <= 1'b0;
    end else if (cmd.load) begin
      ovf_r <= (in_start_year > YEAR_MAX);
    end else if (cmd.walk && (month_r == MONTH_DEC) && (year_r == YEAR_MAX)) begin
      ovf_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      day_r   <= DAY_W'(in_start_day) + DAY_W'(in_add_days);
      month_r <= month_fix;
      year_r  <= in_start_year;
      rem_r   <= in_start_year;
    end else if (cmd.reduce) begin
      if (rem_r >= sub_val) begin
        rem_r <= rem_r - sub_val;
      end
    end else if (cmd.walk) begin
      day_r <= day_r - len;
      if (month_r == MONTH_DEC) begin
        if (year_r != YEAR_MAX) begin
          month_r <= MONTH_JAN;
          year_r  <= year_r + YEAR_W'(1);
          rem_r   <= (rem_r == YEAR_CYCLE - YEAR_W'(1)) ? '0 : rem_r + YEAR_W'(1);
        end
      end else begin
        month_r <= month_r + MONTH_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      res_ovf_r <= ovf_r;
      if (ovf_r) begin
        res_day_r   <= DAY_SAT;
        res_month_r <= MONTH_DEC;
        res_year_r  <= YEAR_MAX;
      end else begin
        res_day_r   <= day_r[DAY_OUT_W-1:0];
        res_month_r <= month_r;
        res_year_r  <= year_r;
      end
    end
  end

  assign out_result_day    = res_day_r;
  assign out_result_month  = res_month_r;
  assign out_result_year   = res_year_r;
  assign out_year_overflow = res_ovf_r;

  `DAD_ASSERT(a_rem_reduced, clk, rst_n,
    cmd.walk |-> rem_r < YEAR_CYCLE)
  `DAD_ASSERT(a_month_in_range, clk, rst_n,
    cmd.walk |=> (month_r >= MONTH_JAN) && (month_r <= MONTH_DEC))
  `DAD_ASSERT_NEVER(a_no_step_when_done, clk, rst_n,
    cmd.walk && sts.done)

endmodule

// ----- rtl/core/date_add_days_core.sv -----
// Gregorian date adder: takes a start date (day, month, year) and a day count and returns
// the resulting date. A start month of 0 reads as January, 13..15 as December. Any result
// past year 9999 (or a start year above 9999) saturates to 31/12/9999 with
// out_year_overflow set. One item is in flight at a time: the item is loaded, the year is
// reduced modulo 400 by conditional subtracts (one per cycle), and the month walk then
// crosses one month per cycle, up to about 2154 month boundaries for a 16-bit day count.
// A finished result waits in the output register while the next item is taken in; a
// result that finds the previous one still stalled at the output holds the core until
// it leaves.
module date_add_days_core
  import dad_pkg::*;
#(
  parameter int unsigned ADD_DAYS_BITS = ADD_DAYS_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [DAY_OUT_W-1:0]     in_start_day,
  input  logic [MONTH_W-1:0]       in_start_month,
  input  logic [YEAR_W-1:0]        in_start_year,
  input  logic [ADD_DAYS_BITS-1:0] in_add_days,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [DAY_OUT_W-1:0]     out_result_day,
  output logic [MONTH_W-1:0]       out_result_month,
  output logic [YEAR_W-1:0]        out_result_year,
  output logic                     out_year_overflow
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  dad_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .sts       (sts)
  );

  dad_datapath #(
    .ADD_DAYS_BITS (ADD_DAYS_BITS)
  ) u_datapath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .in_start_day      (in_start_day),
    .in_start_month    (in_start_month),
    .in_start_year     (in_start_year),
    .in_add_days       (in_add_days),
    .out_result_day    (out_result_day),
    .out_result_month  (out_result_month),
    .out_result_year   (out_result_year),
    .out_year_overflow (out_year_overflow)
  );

endmodule
